[hdl/chs_pkg.sv]
// Shared constants and types for the cell height statistics unit.
package chs_pkg;

  // Fixed field widths
  localparam int CELL_BITS = 12;
  localparam int OCC_BITS  = 13;

  // Parameter defaults
  localparam int CELLS_DEFAULT       = 4096;
  localparam int COUNT_BITS_DEFAULT  = 16;
  localparam int HEIGHT_BITS_DEFAULT = 16;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Memory access strobes from the sequencer to the store
  typedef struct packed {
    logic rd_en;
    logic wr_count;
    logic wr_heights;
  } mem_ctl_t;

endpackage

[hdl/cell_height_statistics_unit.sv]
// Top level of the cell height statistics unit: sequencer, store and result register.
//
// Sample channel (sample_valid / sample_stall): command, cell_index, height.
//   An add raises the cell's saturating count and tracks its lowest, second
//   lowest and highest height. A read returns the cell's statistics and
//   clears it; an add gives no result.
// Result channel (result_valid / result_stall): one transfer per read, with
//   cell_out, sample_count, the three heights (zero for an empty cell) and
//   occupied_cells as left after the read.
// Order: each item is read from the count and height memories when it is taken,
//   then updated and written back in the EXEC state; no new item is taken until
//   it leaves EXEC. A read's result is registered as it leaves EXEC, which a stall can delay.
// Reset: a clearing pass zeroes the count memory, one entry a cycle, from address 0
//   to CELLS-1; sample_stall stays high until it ends. Heights are not cleared.
// Stall: the result register holds while result_stall is high; a further add
//   is still taken, and a further read waits in its update cycle until the
//   result register frees up.
module cell_height_statistics_unit #(
  parameter int CELLS       = chs_pkg::CELLS_DEFAULT,
  parameter int COUNT_BITS  = chs_pkg::COUNT_BITS_DEFAULT,
  parameter int HEIGHT_BITS = chs_pkg::HEIGHT_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic                               command,
  input  logic        [chs_pkg::CELL_BITS-1:0] cell_index,
  input  logic signed [HEIGHT_BITS-1:0]      height,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic        [chs_pkg::CELL_BITS-1:0] cell_out,
  output logic        [COUNT_BITS-1:0]       sample_count,
  output logic signed [HEIGHT_BITS-1:0]      lowest,
  output logic signed [HEIGHT_BITS-1:0]      second_lowest,
  output logic signed [HEIGHT_BITS-1:0]      highest,
  output logic        [chs_pkg::OCC_BITS-1:0]  occupied_cells
);
  import chs_pkg::*;

  localparam int          ADDR_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [31:0] CellsW    = 32'(CELLS);
  localparam logic [ADDR_BITS-1:0] LastAddr = ADDR_BITS'(CELLS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [ADDR_BITS-1:0]         clear_addr;
  logic [OCC_BITS-1:0]          occupied;

  // Item held across its update cycle
  logic                         cmd_q;
  logic [CELL_BITS-1:0]         cell_q;
  logic signed [HEIGHT_BITS-1:0] height_q;
  logic                         in_range_q;
  logic [ADDR_BITS-1:0]         addr_q;

  logic                         take;
  logic                         in_range;
  logic [ADDR_BITS+CELL_BITS-1:0] addr_ext;
  logic [ADDR_BITS-1:0]         in_addr;

  mem_ctl_t                     ctl;
  logic [ADDR_BITS-1:0]         wr_addr;
  logic [COUNT_BITS-1:0]        wr_count_data;
  logic [3*HEIGHT_BITS-1:0]     wr_height_data;
  logic [COUNT_BITS-1:0]        rd_count;
  logic [3*HEIGHT_BITS-1:0]     rd_heights;

  logic signed [HEIGHT_BITS-1:0] cur_low;
  logic signed [HEIGHT_BITS-1:0] cur_second;
  logic signed [HEIGHT_BITS-1:0] cur_high;
  logic [COUNT_BITS-1:0]        upd_count;
  logic signed [HEIGHT_BITS-1:0] upd_low;
  logic signed [HEIGHT_BITS-1:0] upd_second;
  logic signed [HEIGHT_BITS-1:0] upd_high;

  logic                         exec_go;
  logic                         cell_full;
  logic                         result_free;

  // Input transfer and address
  assign sample_stall = (state != ST_IDLE);
  assign take         = sample_valid && !sample_stall;
  assign in_range     = (32'(cell_index) < CellsW);
  assign addr_ext     = {{ADDR_BITS{1'b0}}, cell_index};
  assign in_addr      = addr_ext[ADDR_BITS-1:0];

  // Stored statistics of the cell being worked on
  assign cur_low    = $signed(rd_heights[HEIGHT_BITS-1:0]);
  assign cur_second = $signed(rd_heights[2*HEIGHT_BITS-1:HEIGHT_BITS]);
  assign cur_high   = $signed(rd_heights[3*HEIGHT_BITS-1:2*HEIGHT_BITS]);
  assign cell_full  = in_range_q && (rd_count != '0);

  // A read must find the result register free before it completes
  assign result_free = !result_valid || !result_stall;
  assign exec_go     = (state == ST_EXEC) && ((cmd_q == CMD_ADD) || result_free);

  chs_update #(
    .COUNT_BITS (COUNT_BITS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_update (
    .count     (rd_count),
    .low       (cur_low),
    .second    (cur_second),
    .high      (cur_high),
    .sample    (height_q),
    .new_count (upd_count),
    .new_low   (upd_low),
    .new_second(upd_second),
    .new_high  (upd_high)
  );

  // Memory strobes and write data
  always_comb begin
    ctl.rd_en      = take;
    ctl.wr_count   = 1'b0;
    ctl.wr_heights = 1'b0;
    wr_addr        = addr_q;
    wr_count_data  = upd_count;
    wr_height_data = {upd_high, upd_second, upd_low};
    case (state)
      ST_CLEAR: begin
        ctl.wr_count  = 1'b1;
        wr_addr       = clear_addr;
        wr_count_data = '0;
      end
      ST_EXEC: begin
        if (exec_go && in_range_q) begin
          if (cmd_q == CMD_ADD) begin
            ctl.wr_count   = 1'b1;
            ctl.wr_heights = 1'b1;
          end else if (rd_count != '0) begin
            ctl.wr_count  = 1'b1;
            wr_count_data = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  chs_store #(
    .CELLS      (CELLS),
    .COUNT_BITS (COUNT_BITS),
    .HEIGHT_BITS(HEIGHT_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_store (
    .clk           (clk),
    .ctl           (ctl),
    .rd_addr       (in_addr),
    .wr_addr       (wr_addr),
    .wr_count_data (wr_count_data),
    .wr_height_data(wr_height_data),
    .rd_count_data (rd_count),
    .rd_height_data(rd_heights)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_addr == LastAddr) state_next = ST_IDLE;
      ST_IDLE:  if (take) state_next = ST_EXEC;
      ST_EXEC:  if (exec_go) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + ADDR_BITS'(1);
      end
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q      <= command;
      cell_q     <= cell_index;
      height_q   <= height;
      in_range_q <= in_range;
      addr_q     <= in_addr;
    end
  end

  // Occupied cell total, wraps in its width
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else if (exec_go && in_range_q) begin
      if (cmd_q == CMD_ADD && rd_count == '0) begin
        occupied <= occupied + OCC_BITS'(1);
      end else if (cmd_q == CMD_READ && rd_count != '0) begin
        occupied <= occupied - OCC_BITS'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec_go && cmd_q == CMD_READ) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && cmd_q == CMD_READ) begin
      cell_out <= cell_q;
      if (cell_full) begin
        sample_count   <= rd_count;
        lowest         <= cur_low;
        second_lowest  <= (rd_count == COUNT_BITS'(1)) ? cur_low : cur_second;
        highest        <= cur_high;
        occupied_cells <= occupied - OCC_BITS'(1);
      end else begin
        sample_count   <= '0;
        lowest         <= '0;
        second_lowest  <= '0;
        highest        <= '0;
        occupied_cells <= occupied;
      end
    end
  end

endmodule

[hdl/chs_store.sv]
// Per-cell count memory and height memory, registered read.
module chs_store #(
  parameter int CELLS       = 4096,
  parameter int COUNT_BITS  = 16,
  parameter int HEIGHT_BITS = 16,
  parameter int ADDR_BITS   = 12
) (
  input  logic                     clk,
  input  chs_pkg::mem_ctl_t        ctl,
  input  logic [ADDR_BITS-1:0]     rd_addr,
  input  logic [ADDR_BITS-1:0]     wr_addr,
  input  logic [COUNT_BITS-1:0]    wr_count_data,
  input  logic [3*HEIGHT_BITS-1:0] wr_height_data,
  output logic [COUNT_BITS-1:0]    rd_count_data,
  output logic [3*HEIGHT_BITS-1:0] rd_height_data
);
  import chs_pkg::*;

  logic [COUNT_BITS-1:0]    count_mem  [CELLS];
  logic [3*HEIGHT_BITS-1:0] height_mem [CELLS];

  // Count memory
  always_ff @(posedge clk) begin
    if (ctl.wr_count) begin
      count_mem[wr_addr] <= wr_count_data;
    end
    if (ctl.rd_en) begin
      rd_count_data <= count_mem[rd_addr];
    end
  end

  // Height memory: {highest, second, lowest}
  always_ff @(posedge clk) begin
    if (ctl.wr_heights) begin
      height_mem[wr_addr] <= wr_height_data;
    end
    if (ctl.rd_en) begin
      rd_height_data <= height_mem[rd_addr];
    end
  end

endmodule

[hdl/chs_update.sv]
// Statistics update for one added sample: count, lowest, second lowest, highest.
module chs_update #(
  parameter int COUNT_BITS  = 16,
  parameter int HEIGHT_BITS = 16
) (
  input  logic        [COUNT_BITS-1:0]  count,
  input  logic signed [HEIGHT_BITS-1:0] low,
  input  logic signed [HEIGHT_BITS-1:0] second,
  input  logic signed [HEIGHT_BITS-1:0] high,
  input  logic signed [HEIGHT_BITS-1:0] sample,
  output logic        [COUNT_BITS-1:0]  new_count,
  output logic signed [HEIGHT_BITS-1:0] new_low,
  output logic signed [HEIGHT_BITS-1:0] new_second,
  output logic signed [HEIGHT_BITS-1:0] new_high
);
  import chs_pkg::*;

  logic is_empty;
  logic is_single;
  logic below_low;
  logic below_second;
  logic above_high;

  assign is_empty     = (count == '0);
  assign is_single    = (count == COUNT_BITS'(1));
  assign below_low    = (sample < low);
  assign below_second = (sample < second);
  assign above_high   = (sample > high);

  // Saturating count
  assign new_count = (count == '1) ? count : count + COUNT_BITS'(1);

  // Height tracking; duplicates count towards second lowest
  always_comb begin
    new_low    = low;
    new_second = second;
    new_high   = above_high ? sample : high;
    if (is_empty) begin
      new_low    = sample;
      new_second = sample;
      new_high   = sample;
    end else if (below_low) begin
      new_second = low;
      new_low    = sample;
    end else if (is_single || below_second) begin
      new_second = sample;
    end
  end

endmodule
